@@ design/eftp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Escape-time fractal pixel package
// Shared widths, register indexes, reset values and the saturation helper.
// ----------------------------------------------------------------------------
package eftp_pkg;

	// Field widths
	localparam int COORD_W = 10;          // pixel column / row
	localparam int IDX_W   = 12;          // iteration count and index
	localparam int FX_W    = 32;          // signed Q4.28 values
	localparam int ZOOM_W  = 31;          // unsigned Q3.28 zoom
	localparam int PROD_W  = 64;          // Q8.56 products
	localparam int SUM_W   = 37;          // shifted product plus a Q4.28 term
	localparam int OPND_W  = 33;          // signed multiplier operand

	// Screen mapping: v * 2^MAP_SHIFT / S - MAP_BIAS
	localparam int MAP_SHIFT = 30;
	localparam int DVD_W     = COORD_W + MAP_SHIFT;
	localparam logic [DVD_W:0] MAP_BIAS = (DVD_W + 1)'(64'd1 << 29);

	// Stream widths
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 32;

	// Default screen size
	localparam int SCREEN_W_DEF = 1024;
	localparam int SCREEN_H_DEF = 1024;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_JULIA_MODE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ITERATIONS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_LIMIT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ZOOM_FACTOR    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_RE      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_IM      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SEED_RE        = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SEED_IM        = 3'd7;

	// Register reset values
	localparam logic [IDX_W-1:0]  MAX_ITER_RST = 12'd100;
	localparam logic [FX_W-1:0]   ESC_LIM_RST  = 32'h0400_0000;
	localparam logic [ZOOM_W-1:0] ZOOM_RST     = 31'h1000_0000;

	// Clamp a 37-bit two's complement value into signed 32 bits.
	function automatic logic [FX_W-1:0] sat32(input logic [SUM_W-1:0] v);
		logic all0;
		logic all1;
		begin
			all0 = ~|v[SUM_W-1:FX_W-1];
			all1 = &v[SUM_W-1:FX_W-1];
			if (all0 || all1)
				sat32 = v[FX_W-1:0];
			else if (v[SUM_W-1])
				sat32 = {1'b1, {(FX_W-1){1'b0}}};
			else
				sat32 = {1'b0, {(FX_W-1){1'b1}}};
		end
	endfunction

endpackage
`default_nettype wire

@@ design/escape_time_fractal_pixel.sv @@
`timescale 1ns / 1ps
`default_nettype none
// An item passes the map, scale and place states and then N iterations, N being
//   the iterations run (none with a zero limit), each a multiply state and then
//   an update state on the shared complex-square unit. No new item is taken until
//   the finish state hands the result on; an output stall holds it there.
// Reset: arst_n is asynchronous and active low; it clears the sequencer and
//   loads the registers with Mandelbrot mode, 100 iterations, limit 4.0, zoom 1.0.
// ----------------------------------------------------------------------------
// Escape-time fractal pixel
// Maps one pixel onto the complex plane and iterates z = z^2 + c until the
// squared magnitude passes the escape limit or the iteration limit is hit.
// ----------------------------------------------------------------------------
module escape_time_fractal_pixel #(
	parameter int SCREEN_W = eftp_pkg::SCREEN_W_DEF,
	parameter int SCREEN_H = eftp_pkg::SCREEN_H_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	// Input items
	input  wire                                s_tvalid,
	output logic                               s_tready,
	// px [9:0], py [19:10], zero [23:20]
	input  wire [eftp_pkg::S_TDATA_W-1:0]      s_tdata,
	// Result items
	output logic                               m_tvalid,
	input  wire                                m_tready,
	// out_px [9:0], out_py [19:10], escape_index [31:20]
	output logic [eftp_pkg::M_TDATA_W-1:0]     m_tdata,
	// escaped [0]
	output logic                               m_tuser,
	// Configuration writes
	input  wire                                cfg_we,
	input  wire [eftp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire [eftp_pkg::FX_W-1:0]           cfg_data
);
	import eftp_pkg::*;

	// Sequencer states, one-hot.
	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_MAP   = 7'b0000010,
		ST_SCALE = 7'b0000100,
		ST_PLACE = 7'b0001000,
		ST_MUL   = 7'b0010000,
		ST_UPD   = 7'b0100000,
		ST_FIN   = 7'b1000000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic              julia_q;
	logic [IDX_W-1:0]  max_it_q;
	logic [FX_W-1:0]   esc_lim_q;
	logic [ZOOM_W-1:0] zoom_q;
	logic [FX_W-1:0]   off_re_q;
	logic [FX_W-1:0]   off_im_q;
	logic [FX_W-1:0]   seed_re_q;
	logic [FX_W-1:0]   seed_im_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			julia_q   <= 1'b0;
			max_it_q  <= MAX_ITER_RST;
			esc_lim_q <= ESC_LIM_RST;
			zoom_q    <= ZOOM_RST;
			off_re_q  <= '0;
			off_im_q  <= '0;
			seed_re_q <= '0;
			seed_im_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_JULIA_MODE:     julia_q   <= cfg_data[0];
				REG_MAX_ITERATIONS: max_it_q  <= cfg_data[IDX_W-1:0];
				REG_ESCAPE_LIMIT:   esc_lim_q <= cfg_data;
				REG_ZOOM_FACTOR:    zoom_q    <= cfg_data[ZOOM_W-1:0];
				REG_OFFSET_RE:      off_re_q  <= cfg_data;
				REG_OFFSET_IM:      off_im_q  <= cfg_data;
				REG_SEED_RE:        seed_re_q <= cfg_data;
				REG_SEED_IM:        seed_im_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input handshake: the sequencer takes a new item only when idle. The
	// result register below is separate, so a waiting result does not block.
	logic accept;
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// Screen-to-plane mapping, one unit per axis, started on accept.
	logic              busy_w;
	logic              busy_h;
	logic [FX_W-1:0]   m_re;
	logic [FX_W-1:0]   m_im;

	eftp_map #(.DIVISOR(SCREEN_W)) u_map_re (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.v      (s_tdata[COORD_W-1:0]),
		.busy   (busy_w),
		.m      (m_re)
	);

	eftp_map #(.DIVISOR(SCREEN_H)) u_map_im (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.v      (s_tdata[2*COORD_W-1:COORD_W]),
		.busy   (busy_h),
		.m      (m_im)
	);

	// Working registers.
	logic [COORD_W-1:0] px_q;
	logic [COORD_W-1:0] py_q;
	logic [FX_W-1:0]    zr_q;
	logic [FX_W-1:0]    zi_q;
	logic [FX_W-1:0]    cr_q;
	logic [FX_W-1:0]    ci_q;
	logic [PROD_W-1:0]  prod_a_q;
	logic [PROD_W-1:0]  prod_b_q;
	logic [PROD_W-1:0]  prod_c_q;
	logic [IDX_W-1:0]   it_q;
	logic               check_q;
	logic               esc_q;
	logic [IDX_W-1:0]   idx_q;

	// Shared multiplier unit. In the scale step the first two lanes apply
	// the zoom to the mapped coordinates; otherwise they form zr^2, zi^2
	// and zr*zi for the complex square.
	logic signed [OPND_W-1:0]   op_a1, op_b1, op_a2, op_b2, op_a3, op_b3;
	logic signed [2*OPND_W-1:0] mul1, mul2, mul3;
	logic signed [OPND_W-1:0]   zoom_op;

	assign zoom_op = $signed({2'b00, zoom_q});

	always_comb begin
		op_a3 = $signed({zr_q[FX_W-1], zr_q});
		op_b3 = $signed({zi_q[FX_W-1], zi_q});
		if (state_q == ST_SCALE) begin
			op_a1 = $signed({m_re[FX_W-1], m_re});
			op_b1 = zoom_op;
			op_a2 = $signed({m_im[FX_W-1], m_im});
			op_b2 = zoom_op;
		end else begin
			op_a1 = op_a3;
			op_b1 = op_a3;
			op_a2 = op_b3;
			op_b2 = op_b3;
		end
	end

	assign mul1 = op_a1 * op_b1;
	assign mul2 = op_a2 * op_b2;
	assign mul3 = op_a3 * op_b3;

	// Point on the plane: floor(product / 2^28) plus the offset, clamped.
	logic [SUM_W-1:0] p_re_sum;
	logic [SUM_W-1:0] p_im_sum;
	logic [FX_W-1:0]  p_re;
	logic [FX_W-1:0]  p_im;

	assign p_re_sum = {prod_a_q[PROD_W-1], prod_a_q[PROD_W-1:28]}
	                + {{(SUM_W-FX_W){off_re_q[FX_W-1]}}, off_re_q};
	assign p_im_sum = {prod_b_q[PROD_W-1], prod_b_q[PROD_W-1:28]}
	                + {{(SUM_W-FX_W){off_im_q[FX_W-1]}}, off_im_q};
	assign p_re = sat32(p_re_sum);
	assign p_im = sat32(p_im_sum);

	// Iteration update: re = (zr^2 - zi^2) / 2^28 + cr, im = zr*zi / 2^27 + ci.
	logic [PROD_W-1:0] sq_diff;
	logic [SUM_W-1:0]  nr_sum;
	logic [SUM_W-1:0]  ni_sum;
	logic [FX_W-1:0]   nr;
	logic [FX_W-1:0]   ni;

	assign sq_diff = prod_a_q - prod_b_q;
	assign nr_sum  = {sq_diff[PROD_W-1], sq_diff[PROD_W-1:28]}
	               + {{(SUM_W-FX_W){cr_q[FX_W-1]}}, cr_q};
	assign ni_sum  = prod_c_q[PROD_W-1:27]
	               + {{(SUM_W-FX_W){ci_q[FX_W-1]}}, ci_q};
	assign nr = sat32(nr_sum);
	assign ni = sat32(ni_sum);

	// Escape test on the squares of the current z. Each square is at most
	// 2^62, so the 64-bit sum cannot wrap; its upper half is Q8.24.
	logic [PROD_W-1:0] mag_sum;
	logic              over;

	assign mag_sum = prod_a_q + prod_b_q;
	assign over    = (mag_sum[PROD_W-1:PROD_W-FX_W] > esc_lim_q);

	// Result register.
	logic               out_valid_q;
	logic [COORD_W-1:0] out_px_q;
	logic [COORD_W-1:0] out_py_q;
	logic               out_esc_q;
	logic [IDX_W-1:0]   out_idx_q;
	logic               load_out;

	assign load_out = (state_q == ST_FIN) && (!out_valid_q || m_tready);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept)
						state_q <= ST_MAP;
				end
				ST_MAP: begin
					if (!busy_w && !busy_h)
						state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					state_q <= ST_PLACE;
				end
				ST_PLACE: begin
					// A zero iteration limit runs no iteration at all.
					if (max_it_q == '0)
						state_q <= ST_FIN;
					else
						state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if ((check_q && over) || (it_q == max_it_q))
						state_q <= ST_FIN;
					else
						state_q <= ST_MUL;
				end
				ST_FIN: begin
					if (load_out)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			px_q <= s_tdata[COORD_W-1:0];
			py_q <= s_tdata[2*COORD_W-1:COORD_W];
		end

		if ((state_q == ST_SCALE) || (state_q == ST_MUL)) begin
			prod_a_q <= mul1[PROD_W-1:0];
			prod_b_q <= mul2[PROD_W-1:0];
			prod_c_q <= mul3[PROD_W-1:0];
		end

		if (state_q == ST_PLACE) begin
			// Mandelbrot starts from zero with c at the point; Julia starts
			// from the point with c at the seed.
			if (julia_q) begin
				zr_q <= p_re;
				zi_q <= p_im;
				cr_q <= seed_re_q;
				ci_q <= seed_im_q;
			end else begin
				zr_q <= '0;
				zi_q <= '0;
				cr_q <= p_re;
				ci_q <= p_im;
			end
			it_q    <= '0;
			check_q <= 1'b0;
			esc_q   <= 1'b0;
			idx_q   <= '0;
		end

		if (state_q == ST_UPD) begin
			// The starting z is never tested; each later z is tested before
			// the limit check, so the last iterate can still escape.
			if (check_q && over) begin
				esc_q <= 1'b1;
				idx_q <= it_q - 1'b1;
			end else if (it_q != max_it_q) begin
				zr_q    <= nr;
				zi_q    <= ni;
				it_q    <= it_q + 1'b1;
				check_q <= 1'b1;
			end
		end

		if (load_out) begin
			out_px_q  <= px_q;
			out_py_q  <= py_q;
			out_esc_q <= esc_q;
			out_idx_q <= idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_idx_q, out_py_q, out_px_q};
	assign m_tuser  = out_esc_q;

endmodule
`default_nettype wire

@@ design/eftp_map.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Screen coordinate mapper
// Computes sat32(floor(v * 2^30 / DIVISOR) - 2^29). A power-of-two divisor
// is a shift; any other divisor uses two constant multiplications, one of
// them by a rounded-up reciprocal; the quotient is registered on start.
// ----------------------------------------------------------------------------
module eftp_map #(
	parameter int DIVISOR = eftp_pkg::SCREEN_W_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                start,
	input  wire [eftp_pkg::COORD_W-1:0]        v,
	output logic                               busy,
	output logic [eftp_pkg::FX_W-1:0]          m
);
	import eftp_pkg::*;

	localparam bool_pow2 = ((DIVISOR & (DIVISOR - 1)) == 0);
	localparam int  SH    = $clog2(DIVISOR);

	logic [DVD_W-1:0] quot;
	logic [DVD_W:0]   diff;

	generate
		if (bool_pow2) begin : g_shift
			logic [COORD_W-1:0] v_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					v_q <= '0;
				else if (start)
					v_q <= v;
			end

			assign quot = {v_q, {MAP_SHIFT{1'b0}}} >> SH;
			assign busy = 1'b0;
		end else begin : g_div
			// With 2^30 = Q * D + R, floor(v * 2^30 / D) = v * Q + floor(v * R / D).
			// The second term uses the reciprocal 2^34 / D rounded up. It is
			// exact because v * R times the rounding error of that reciprocal
			// stays below 2^34 for a 10-bit v and D up to 4096.
			localparam int RCP_SH = 34;
			localparam int RK_W   = 46;
			localparam int FP_W   = COORD_W + RK_W;
			localparam longint unsigned Q_L = (64'd1 << MAP_SHIFT) / DIVISOR;
			localparam longint unsigned R_L = (64'd1 << MAP_SHIFT) % DIVISOR;
			localparam longint unsigned M_L = ((64'd1 << RCP_SH) + DIVISOR - 1) / DIVISOR;
			localparam logic [DVD_W-1:0] QUO_K = DVD_W'(Q_L);
			localparam logic [RK_W-1:0]  RM_K  = RK_W'(R_L * M_L);

			logic [DVD_W-1:0] whole_w;
			logic [FP_W-1:0]  frac_w;
			logic [DVD_W-1:0] quot_q;

			assign whole_w = {{(DVD_W-COORD_W){1'b0}}, v} * QUO_K;
			assign frac_w  = {{RK_W{1'b0}}, v} * {{COORD_W{1'b0}}, RM_K};

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					quot_q <= '0;
				else if (start)
					quot_q <= whole_w
					        + {{(DVD_W-FP_W+RCP_SH){1'b0}}, frac_w[FP_W-1:RCP_SH]};
			end

			assign quot = quot_q;
			assign busy = 1'b0;
		end
	endgenerate

	// The quotient is never negative, so only the upper bound can clamp.
	assign diff = {1'b0, quot} - MAP_BIAS;

	always_comb begin
		if (!diff[DVD_W] && (|diff[DVD_W-1:FX_W-1]))
			m = {1'b0, {(FX_W-1){1'b1}}};
		else
			m = diff[FX_W-1:0];
	end

endmodule
`default_nettype wire

@@ design/eftp_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Escape-time fractal pixel port checker
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module eftp_chk (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              s_tvalid,
	input wire                              s_tready,
	input wire                              m_tvalid,
	input wire                              m_tready,
	input wire [eftp_pkg::M_TDATA_W-1:0]    m_tdata,
	input wire                              m_tuser
);
	import eftp_pkg::*;

	// A held result keeps its payload until taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// A result only goes away when taken.
	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(m_tvalid) |-> $past(m_tready))
		else $error("result dropped without handshake");

	// The block takes no further item while it works on an accepted one.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
		else $error("input accepted while an item is in progress");

	// A pixel that did not escape reports index zero.
	a_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[M_TDATA_W-1:2*COORD_W] == '0)
		else $error("nonzero escape index on an inside pixel");

endmodule

bind escape_time_fractal_pixel eftp_chk u_chk (.*);
`default_nettype wire

@@ sim/escape_time_fractal_pixel_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape-time fractal pixel checker
// Watches the configuration port and both item channels, predicts the escape
// result of every accepted pixel and compares it with the block's output.
// ----------------------------------------------------------------------------
module escape_time_fractal_pixel_checker #(
	parameter int SCREEN_W = eftp_pkg::SCREEN_W_DEF,
	parameter int SCREEN_H = eftp_pkg::SCREEN_H_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             s_tvalid,
	input  wire                             s_tready,
	// px [9:0], py [19:10], zero [23:20]
	input  wire [eftp_pkg::S_TDATA_W-1:0]   s_tdata,
	input  wire                             m_tvalid,
	input  wire                             m_tready,
	// out_px [9:0], out_py [19:10], escape_index [31:20]
	input  wire [eftp_pkg::M_TDATA_W-1:0]   m_tdata,
	// escaped [0]
	input  wire                             m_tuser,
	input  wire                             cfg_we,
	input  wire [eftp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire [eftp_pkg::FX_W-1:0]        cfg_data,
	output int                              fail_count,
	output int                              pending
);

	localparam longint Q428_MAX = 64'sd2147483647;
	localparam longint Q428_MIN = -64'sd2147483648;

	typedef struct packed {
		logic [9:0]  px;
		logic [9:0]  py;
		logic        escaped;
		logic [11:0] iter_index;
	} pixel_result_t;

	// Shadow copy of the configuration registers.
	logic               julia;
	logic [11:0]        iter_limit;
	logic [31:0]        esc_limit;
	logic [30:0]        zoom;
	logic signed [31:0] off_re;
	logic signed [31:0] off_im;
	logic signed [31:0] seed_re;
	logic signed [31:0] seed_im;

	pixel_result_t result_q[$];
	pixel_result_t want;

	function automatic longint clamp_q428(input longint v);
		if (v > Q428_MAX)
			return Q428_MAX;
		if (v < Q428_MIN)
			return Q428_MIN;
		return v;
	endfunction

	// Screen position to plane position: linear map onto [-2, 2), zoom, shift.
	function automatic longint map_coord(input logic [9:0] v, input int span,
			input logic signed [31:0] shift);
		longint m;
		longint scaled;
		m = clamp_q428(((longint'(v) << 30) / longint'(span)) - (longint'(1) << 29));
		scaled = (m * longint'(zoom)) >>> 28;
		return clamp_q428(scaled + longint'(shift));
	endfunction

	function automatic pixel_result_t predict_pixel(input logic [9:0] x, input logic [9:0] y);
		pixel_result_t r;
		longint pr, pim, zr, zi, cr, ci, rr, ii, ri;
		logic [63:0] mag;
		int n;
		logic done;
		pr = map_coord(x, SCREEN_W, off_re);
		pim = map_coord(y, SCREEN_H, off_im);
		if (julia) begin
			zr = pr;
			zi = pim;
			cr = longint'(seed_re);
			ci = longint'(seed_im);
		end else begin
			zr = 0;
			zi = 0;
			cr = pr;
			ci = pim;
		end
		r.px = x;
		r.py = y;
		r.escaped = 1'b0;
		r.iter_index = '0;
		n = 0;
		done = 1'b0;
		while (!done && n < int'(iter_limit)) begin
			rr = zr * zr;
			ii = zi * zi;
			ri = zr * zi;
			zr = clamp_q428(((rr - ii) >>> 28) + cr);
			zi = clamp_q428((ri >>> 27) + ci);
			// The sum of squares can reach 2^63, so it is taken as unsigned.
			mag = zr * zr + zi * zi;
			mag = mag >> 32;
			if (mag > {32'd0, esc_limit}) begin
				r.escaped = 1'b1;
				r.iter_index = 12'(n);
				done = 1'b1;
			end
			n++;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		if (fail_count < 100)
			$display("[%0t] mismatch: %s", $realtime, msg);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			julia <= 1'b0;
			iter_limit <= 12'd100;
			esc_limit <= 32'h0400_0000;
			zoom <= 31'h1000_0000;
			off_re <= '0;
			off_im <= '0;
			seed_re <= '0;
			seed_im <= '0;
			result_q.delete();
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					eftp_pkg::REG_JULIA_MODE:     julia <= cfg_data[0];
					eftp_pkg::REG_MAX_ITERATIONS: iter_limit <= cfg_data[11:0];
					eftp_pkg::REG_ESCAPE_LIMIT:   esc_limit <= cfg_data;
					eftp_pkg::REG_ZOOM_FACTOR:    zoom <= cfg_data[30:0];
					eftp_pkg::REG_OFFSET_RE:      off_re <= cfg_data;
					eftp_pkg::REG_OFFSET_IM:      off_im <= cfg_data;
					eftp_pkg::REG_SEED_RE:        seed_re <= cfg_data;
					eftp_pkg::REG_SEED_IM:        seed_im <= cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				result_q.push_back(predict_pixel(s_tdata[9:0], s_tdata[19:10]));
			if (m_tvalid && m_tready) begin
				if (result_q.size() == 0) begin
					report_mismatch($sformatf("result for px %0d py %0d with none outstanding",
						m_tdata[9:0], m_tdata[19:10]));
				end else begin
					want = result_q.pop_front();
					if (m_tdata[9:0] !== want.px)
						report_mismatch($sformatf("out_px %0d, expected %0d (py %0d)",
							m_tdata[9:0], want.px, want.py));
					if (m_tdata[19:10] !== want.py)
						report_mismatch($sformatf("out_py %0d, expected %0d (px %0d)",
							m_tdata[19:10], want.py, want.px));
					if (m_tuser !== want.escaped)
						report_mismatch($sformatf("px %0d py %0d: escaped %0b, expected %0b",
							want.px, want.py, m_tuser, want.escaped));
					if (m_tdata[31:20] !== want.iter_index)
						report_mismatch($sformatf("px %0d py %0d: escape_index %0d, expected %0d",
							want.px, want.py, m_tdata[31:20], want.iter_index));
				end
			end
			pending = result_q.size();
		end
	end

endmodule

@@ sim/escape_time_fractal_pixel_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape-time fractal pixel regression
// Drives pixel items through the block under random input gaps and output
// stalls, across Mandelbrot and Julia settings, while the checker predicts
// and compares every result.
// ----------------------------------------------------------------------------
module escape_time_fractal_pixel_test;

	// The limit lies above the worst correct run, in which every item runs its
	// full iteration count behind the longest gap and the longest stall.
	localparam int unsigned RUN_LIMIT = 6_000_000;

	logic                               clk;
	logic                               arst_n;
	logic                               s_tvalid;
	logic                               s_tready;
	// px [9:0], py [19:10], zero [23:20]
	logic [eftp_pkg::S_TDATA_W-1:0]     s_tdata;
	logic                               m_tvalid;
	logic                               m_tready;
	// out_px [9:0], out_py [19:10], escape_index [31:20]
	logic [eftp_pkg::M_TDATA_W-1:0]     m_tdata;
	// escaped [0]
	logic                               m_tuser;
	logic                               cfg_we;
	logic [eftp_pkg::CFG_IDX_W-1:0]     cfg_index;
	logic [eftp_pkg::FX_W-1:0]          cfg_data;

	int fail_count;
	int pending;

	// When set, the sender or the receiver runs without any idling.
	logic tx_calm = 1'b0;
	logic rx_calm = 1'b0;

	int unsigned cycle_count = 0;

	escape_time_fractal_pixel u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	escape_time_fractal_pixel_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// A hung block or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("escape_time_fractal_pixel regression: fail");
			$finish;
		end
	end

	// Gaps between input items: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (tx_calm || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 24);
		return $urandom_range(25, 100);
	endfunction

	function automatic int pick_stall();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 20);
		return $urandom_range(21, 150);
	endfunction

	// Result side: tready drops for random stretches unless the phase is calm.
	initial begin
		int stall;
		m_tready = 1'b0;
		stall = 0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else if (!rx_calm && $urandom_range(0, 99) < 30) begin
				m_tready <= 1'b0;
				stall = pick_stall() - 1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Offers one pixel item and returns at the edge where it is accepted.
	// Valid stays high afterwards, so back-to-back items never lower it.
	task automatic send_pixel(input logic [9:0] x, input logic [9:0] y);
		int gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			s_tdata <= 24'($urandom);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {4'd0, y, x};
		do @(posedge clk); while (!s_tready);
	endtask

	// Stops offering items and waits until every result is back, then lets
	// the block settle before any register write.
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic [eftp_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Writes all eight registers. Bits above a register's width are random,
	// so the block must ignore them.
	task automatic configure(input logic julia, input logic [11:0] iters,
			input logic [31:0] limit, input logic [30:0] zoom,
			input logic [31:0] ore, input logic [31:0] oim,
			input logic [31:0] seed_r, input logic [31:0] seed_i);
		write_reg(eftp_pkg::REG_JULIA_MODE, {31'($urandom), julia});
		write_reg(eftp_pkg::REG_MAX_ITERATIONS, {20'($urandom), iters});
		write_reg(eftp_pkg::REG_ESCAPE_LIMIT, limit);
		write_reg(eftp_pkg::REG_ZOOM_FACTOR, {1'($urandom), zoom});
		write_reg(eftp_pkg::REG_OFFSET_RE, ore);
		write_reg(eftp_pkg::REG_OFFSET_IM, oim);
		write_reg(eftp_pkg::REG_SEED_RE, seed_r);
		write_reg(eftp_pkg::REG_SEED_IM, seed_i);
	endtask

	// Picks a random view. Iteration counts stay small for most phases so
	// the run stays short; zooms below one keep many pixels near the set's
	// boundary, where escape indexes spread out.
	task automatic random_settings();
		logic        julia;
		logic [11:0] iters;
		logic [31:0] limit;
		logic [30:0] zoom;
		logic [31:0] ore, oim, seed_r, seed_i;
		julia = 1'($urandom);
		case ($urandom_range(0, 9))
			0:         iters = 12'($urandom_range(1, 4));
			1, 2, 3, 4, 5: iters = 12'($urandom_range(5, 64));
			6, 7, 8:   iters = 12'($urandom_range(65, 200));
			default:   iters = 12'($urandom_range(0, 12));
		endcase
		case ($urandom_range(0, 7))
			0:       limit = 32'h0000_0000;
			1:       limit = 32'hFFFF_FFFF;
			2:       limit = $urandom;
			3:       limit = $urandom_range(0, 32'h0800_0000);
			default: limit = 32'h0400_0000;
		endcase
		case ($urandom_range(0, 7))
			0:       zoom = 31'h0000_0000;
			1:       zoom = 31'h7FFF_FFFF;
			2:       zoom = 31'($urandom);
			3:       zoom = 31'($urandom_range(32'h1000_0000, 32'h7FFF_FFFF));
			default: zoom = 31'($urandom_range(32'h0040_0000, 32'h1000_0000));
		endcase
		case ($urandom_range(0, 5))
			0: begin
				ore = $urandom;
				oim = $urandom;
			end
			1: begin
				ore = '0;
				oim = '0;
			end
			default: begin
				// Real part in [-2, 1], imaginary part in [-1, 1].
				ore = $urandom_range(0, 32'h3000_0000) - 32'h2000_0000;
				oim = $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
			end
		endcase
		if ($urandom_range(0, 4) == 0) begin
			seed_r = $urandom;
			seed_i = $urandom;
		end else begin
			seed_r = $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
			seed_i = $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
		end
		configure(julia, iters, limit, zoom, ore, oim, seed_r, seed_i);
	endtask

	// One phase of random pixels. Now and then the sender holds off until
	// every outstanding result has come back.
	task automatic run_phase(input int count);
		int k;
		tx_calm = ($urandom_range(0, 3) == 0);
		rx_calm = ($urandom_range(0, 3) == 0);
		for (k = 0; k < count; k++) begin
			if ($urandom_range(0, 49) == 0)
				drain();
			send_pixel(10'($urandom), 10'($urandom));
		end
		drain();
	endtask

	initial begin
		int ph;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: Mandelbrot, 100 iterations, limit 4.0, zoom 1.0.
		// Screen corners, the centre (c = 0, never escapes) and c = -1, which
		// settles into an orbit of period two.
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd1023, 10'd1023);
		send_pixel(10'd0, 10'd1023);
		send_pixel(10'd1023, 10'd0);
		send_pixel(10'd512, 10'd512);
		send_pixel(10'd511, 10'd511);
		send_pixel(10'd256, 10'd512);
		drain();

		// Iteration limit of zero: nothing runs, so nothing escapes.
		configure(1'b0, 12'd0, 32'h0400_0000, 31'h1000_0000, 32'd0, 32'd0, 32'd0, 32'd0);
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd1023, 10'd511);
		drain();

		// Escape limit of zero: a first iterate with |z|^2 >= 2^-24 escapes.
		configure(1'b0, 12'd1, 32'h0000_0000, 31'h1000_0000, 32'd0, 32'd0, 32'd0, 32'd0);
		send_pixel(10'd512, 10'd512);
		send_pixel(10'd0, 10'd0);
		drain();

		// Largest zoom and extreme offsets: the mapped point and the orbit
		// both saturate, and a limit above any magnitude keeps it going.
		configure(1'b0, 12'd20, 32'hFFFF_FFFF, 31'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd0);
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd1023, 10'd1023);
		drain();

		// Julia set around c = -0.8 + 0.156i.
		configure(1'b1, 12'd60, 32'h0400_0000, 31'h1000_0000,
			32'd0, 32'd0, 32'hF333_3333, 32'd41875931);
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd512, 10'd512);
		send_pixel(10'd700, 10'd300);
		drain();

		// Julia with zero zoom (every pixel lands on the offset) and the
		// most extreme constants.
		configure(1'b1, 12'd30, 32'h0400_0000, 31'h0000_0000,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
		send_pixel(10'd5, 10'd5);
		send_pixel(10'd1000, 10'd1000);
		drain();

		// Largest iteration limit on two points inside the set and one outside.
		configure(1'b0, 12'd4095, 32'h0400_0000, 31'h1000_0000, 32'd0, 32'd0, 32'd0, 32'd0);
		send_pixel(10'd512, 10'd512);
		send_pixel(10'd256, 10'd512);
		send_pixel(10'd300, 10'd700);
		drain();

		for (ph = 0; ph < 14; ph++) begin
			random_settings();
			run_phase(125);
		end

		// Give a stray extra result time to show up before the verdict.
		repeat (300) @(negedge clk);
		if (fail_count == 0)
			$display("escape_time_fractal_pixel regression: pass");
		else
			$display("escape_time_fractal_pixel regression: fail");
		$finish;
	end

endmodule

@@ sim.f @@
design/eftp_pkg.sv
design/eftp_map.sv
design/escape_time_fractal_pixel.sv
design/eftp_chk.sv
sim/escape_time_fractal_pixel_checker.sv
sim/escape_time_fractal_pixel_test.sv
